FILE: rtl/ranked_top_list_insert_top_assert.svh
// Assertion macros shared by the ranked top list RTL.
`ifndef RANKED_TOP_LIST_INSERT_TOP_ASSERT_SVH
`define RANKED_TOP_LIST_INSERT_TOP_ASSERT_SVH

// Checked on every rising clock edge outside reset.
`define RTLI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Checked on every rising clock edge, reset included.
`define RTLI_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`endif

FILE: rtl/rtli_pkg.sv
// Package with the constants, types and helpers of the ranked top list.
package rtli_pkg;

  localparam int MAX_ENTRIES = 8;
  localparam int NUM_LISTS   = 16;

  localparam int LIST_IN_W = 4;
  localparam int PTS_W     = 24;
  localparam int TAG_W     = 16;
  localparam int HER_W     = 16;
  localparam int TIME_W    = 20;
  localparam int RRANK_W   = 3;
  localparam int POS_W     = 4;

  localparam int LIST_W = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
  localparam int RANK_W = $clog2(MAX_ENTRIES);
  localparam int FILL_W = $clog2(MAX_ENTRIES + 1);
  localparam int CMP_W  = FILL_W + RRANK_W;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_READ   = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_ZERO   = 2'd1,
    ST_BELOW  = 2'd2,
    ST_BEYOND = 2'd3
  } status_e;

  typedef enum logic {
    S_IDLE,
    S_EVAL
  } state_e;

  typedef logic [LIST_W-1:0] list_t;

  typedef struct packed {
    logic [PTS_W-1:0]  points;
    logic [TAG_W-1:0]  player_tag;
    logic [HER_W-1:0]  herring_count;
    logic [TIME_W-1:0] elapsed_time;
  } rec_t;

  typedef struct packed {
    logic  rd_en;
    list_t rd_addr;
    logic  wr_en;
    list_t wr_addr;
    rec_t  new_rec;
  } cell_ctl_t;

  typedef struct packed {
    rec_t rec;
    logic here;
    logic valid;
  } link_t;

  function automatic list_t wrap_list(logic [LIST_IN_W-1:0] idx);
    list_t r;
    r = '0;
    for (int i = 0; i < 2 ** LIST_IN_W; i++) begin
      if (idx == LIST_IN_W'(i)) begin
        r = LIST_W'(i % NUM_LISTS);
      end
    end
    return r;
  endfunction

endpackage

FILE: rtl/rtli_in_if.sv
// Request channel interface of the ranked top list.
interface rtli_in_if;
  import rtli_pkg::*;

  logic                 valid;
  logic                 ready;
  op_e                  operation;
  logic [LIST_IN_W-1:0] list_index;
  logic [PTS_W-1:0]     points;
  logic [TAG_W-1:0]     player_tag;
  logic [HER_W-1:0]     herring_count;
  logic [TIME_W-1:0]    elapsed_time;
  logic [RRANK_W-1:0]   read_rank;

  modport source (
    output valid, operation, list_index, points, player_tag, herring_count,
           elapsed_time, read_rank,
    input  ready
  );

  modport sink (
    input  valid, operation, list_index, points, player_tag, herring_count,
           elapsed_time, read_rank,
    output ready
  );
endinterface

FILE: rtl/rtli_out_if.sv
// Result channel interface of the ranked top list.
interface rtli_out_if;
  import rtli_pkg::*;

  logic              valid;
  logic              ready;
  logic [POS_W-1:0]  position;
  status_e           status;
  logic [POS_W-1:0]  entry_count;
  logic [PTS_W-1:0]  out_points;
  logic [TAG_W-1:0]  out_player_tag;
  logic [HER_W-1:0]  out_herring_count;
  logic [TIME_W-1:0] out_elapsed_time;

  modport source (
    output valid, position, status, entry_count, out_points, out_player_tag,
           out_herring_count, out_elapsed_time,
    input  ready
  );

  modport sink (
    input  valid, position, status, entry_count, out_points, out_player_tag,
           out_herring_count, out_elapsed_time,
    output ready
  );
endinterface

FILE: rtl/rtli_cell.sv
// One rank cell: stores this rank for every list and does compare and shift.
module rtli_cell (
  input  logic               clk_i,
  input  rtli_pkg::cell_ctl_t ctl_i,
  input  logic               valid_i,
  input  rtli_pkg::link_t    prev_i,
  output rtli_pkg::link_t    link_o
);
  import rtli_pkg::*;

  rec_t mem_q [NUM_LISTS];
  rec_t rd_q;
  logic here;
  logic we;
  rec_t wdata;

  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      rd_q <= mem_q[ctl_i.rd_addr];
    end
    if (we) begin
      mem_q[ctl_i.wr_addr] <= wdata;
    end
  end

  // The new record belongs at or above this rank when it beats the stored one.
  always_comb begin
    here   = !(valid_i && (ctl_i.new_rec.points <= rd_q.points));
    we     = ctl_i.wr_en && ((here && !prev_i.here) || (prev_i.here && prev_i.valid));
    wdata  = prev_i.here ? prev_i.rec : ctl_i.new_rec;
    link_o = '{rec: rd_q, here: here, valid: valid_i};
  end

endmodule

FILE: rtl/rtli_ctrl.sv
// Sequencer, list fill counters and result register of the ranked top list.
`include "ranked_top_list_insert_top_assert.svh"

module rtli_ctrl (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  rtli_in_if.sink                             in_i,
  rtli_out_if.source                          out_o,
  output rtli_pkg::cell_ctl_t                 ctl_o,
  output logic [rtli_pkg::MAX_ENTRIES-1:0]    valid_o,
  input  logic [rtli_pkg::MAX_ENTRIES-1:0]    here_i,
  input  rtli_pkg::rec_t                      rec_i [rtli_pkg::MAX_ENTRIES]
);
  import rtli_pkg::*;

  state_e             state_q, state_d;
  op_e                op_q;
  list_t              list_q;
  rec_t               new_q;
  logic [RRANK_W-1:0] rrank_q;
  logic [FILL_W-1:0]  fill_q [NUM_LISTS];

  logic               out_valid_q, out_valid_d;
  logic [POS_W-1:0]   pos_q, pos_d;
  status_e            status_q, status_d;
  logic [POS_W-1:0]   cnt_q, cnt_d;
  rec_t               orec_q, orec_d;

  logic               accept;
  logic               done;
  logic               rd_ok;
  logic               commit;
  rec_t               sel_rec;
  logic [FILL_W-1:0]  num;
  logic [FILL_W-1:0]  num_new;
  logic [FILL_W-1:0]  pos_cnt;

  assign in_i.ready = (state_q == S_IDLE);
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    num     = fill_q[list_q];
    done    = !out_valid_q || out_o.ready;
    rd_ok   = CMP_W'(rrank_q) < CMP_W'(num);
    sel_rec = rec_i[RANK_W'(rrank_q)];
    pos_cnt = FILL_W'($countones(~here_i));
    num_new = (num < FILL_W'(MAX_ENTRIES)) ? num + 1'b1 : num;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      valid_o[i] = num > FILL_W'(i);
    end
  end

  always_comb begin
    state_d     = state_q;
    commit      = 1'b0;
    out_valid_d = out_valid_q && !out_o.ready;
    pos_d       = pos_q;
    status_d    = status_q;
    cnt_d       = cnt_q;
    orec_d      = orec_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        if (done) begin
          state_d     = S_IDLE;
          out_valid_d = 1'b1;
          cnt_d       = POS_W'(num);
          orec_d      = '0;
          pos_d       = POS_W'(MAX_ENTRIES);
          status_d    = ST_OK;
          if (op_q == OP_READ) begin
            if (rd_ok) begin
              pos_d  = POS_W'(rrank_q);
              orec_d = sel_rec;
            end else begin
              status_d = ST_BEYOND;
            end
          end else if (new_q.points == '0) begin
            status_d = ST_ZERO;
          end else if (!here_i[MAX_ENTRIES-1]) begin
            status_d = ST_BELOW;
          end else begin
            commit = 1'b1;
            pos_d  = POS_W'(pos_cnt);
            cnt_d  = POS_W'(num_new);
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    ctl_o.rd_en   = accept;
    ctl_o.rd_addr = wrap_list(in_i.list_index);
    ctl_o.wr_en   = commit;
    ctl_o.wr_addr = list_q;
    ctl_o.new_rec = new_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_LISTS; i++) begin
        fill_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (commit) begin
        fill_q[list_q] <= num_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= in_i.operation;
      list_q  <= wrap_list(in_i.list_index);
      rrank_q <= in_i.read_rank;
      new_q   <= '{points: in_i.points, player_tag: in_i.player_tag,
                   herring_count: in_i.herring_count,
                   elapsed_time: in_i.elapsed_time};
    end
    pos_q    <= pos_d;
    status_q <= status_d;
    cnt_q    <= cnt_d;
    orec_q   <= orec_d;
  end

  assign out_o.valid             = out_valid_q;
  assign out_o.position          = pos_q;
  assign out_o.status            = status_q;
  assign out_o.entry_count       = cnt_q;
  assign out_o.out_points        = orec_q.points;
  assign out_o.out_player_tag    = orec_q.player_tag;
  assign out_o.out_herring_count = orec_q.herring_count;
  assign out_o.out_elapsed_time  = orec_q.elapsed_time;

  `RTLI_ASSERT(a_here_sorted, (state_q == S_EVAL) |-> (((here_i << 1) & ~here_i) == '0), "rank compare results are not monotonic")
  `RTLI_ASSERT(a_fill_step, (commit && (num != FILL_W'(MAX_ENTRIES))) |=> (fill_q[$past(list_q)] == $past(num) + 1'b1), "list fill did not grow after an insert")
  `RTLI_ASSERT(a_read_nonzero, ((state_q == S_EVAL) && (op_q == OP_READ) && rd_ok) |-> (sel_rec.points != '0), "stored record read back with zero points")
  `RTLI_ASSERT(a_single_write, commit |=> !commit, "an insert was written twice")
  `RTLI_ASSERT_ALWAYS(a_fill_bound, (state_q == S_EVAL) |-> (num <= FILL_W'(MAX_ENTRIES)), "list fill exceeds the list length")

endmodule

FILE: rtl/ranked_top_list_insert_top.sv
// Top level of the ranked top list: sequencer plus a chain of rank cells.
// Keeps NUM_LISTS lists of up to MAX_ENTRIES records sorted by descending
// points, one rank cell per rank, each cell holding its rank of every list
// in a small memory. When a request beat is accepted the cells read the
// addressed list; then, in the evaluate state, each cell compares the new
// points with its record, takes either the new record or its upper
// neighbor's record, and the result is loaded into the output register. A
// new beat is taken while a finished result waits at the output, and the
// evaluate state stretches only while the output register is still full.
// No clearing pass is needed after reset.
module ranked_top_list_insert_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  rtli_in_if.sink    in_i,
  rtli_out_if.source out_o
);
  import rtli_pkg::*;

  cell_ctl_t              ctl;
  logic [MAX_ENTRIES-1:0] valid;
  logic [MAX_ENTRIES-1:0] here;
  rec_t                   rec  [MAX_ENTRIES];
  link_t                  link [MAX_ENTRIES];

  rtli_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .out_o   (out_o),
    .ctl_o   (ctl),
    .valid_o (valid),
    .here_i  (here),
    .rec_i   (rec)
  );

  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    link_t prev;

    if (g == 0) begin : g_head
      assign prev = '0;
    end else begin : g_body
      assign prev = link[g-1];
    end

    rtli_cell u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .valid_i (valid[g]),
      .prev_i  (prev),
      .link_o  (link[g])
    );

    assign here[g] = link[g].here;
    assign rec[g]  = link[g].rec;
  end

endmodule
